>>> rtl/csa_pkg.sv
// shared types and constants of the cone surface anchor unit
package csa_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COMP_W        = 32;
	localparam int RAD_W         = 64;
	localparam int ROOT_W        = 32;
	localparam int REM_W         = 35;
	localparam int DEN_W         = 36;
	localparam int SQRT_STEPS    = 32;
	localparam int DIV_STEPS     = 32;
	localparam int QUEUE_DEPTH   = 4;
	localparam int DATA_W        = 96;
	localparam int USER_W        = 8;

	// flags that follow an item down the back pipeline
	typedef struct packed {
		logic cap;
		logic degen;
	} csa_tag_t;

	// vector components and classification, carried past the root
	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
		csa_tag_t                 tag;
	} csa_side_t;

	// one classified item as held in the queue
	typedef struct packed {
		logic [RAD_W-1:0] s;
		csa_side_t        side;
	} csa_item_t;

endpackage

>>> rtl/csa_front.sv
// front end: takes vectors, squares components and classifies cap, side and zero cases
module csa_front import csa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DATA_W-1:0]   in_data,
	input  logic                q_full,
	output logic                q_push,
	output csa_item_t           q_item
);

	logic                       v_s1, v_s2;
	logic                       en;
	logic signed [COMP_W-1:0]   x_in, y_in, z_in;
	logic [COMP_W-1:0]          ax, ay, az;
	logic signed [COMP_W-1:0]   x_s1, y_s1, z_s1;
	logic [2*COMP_W-1:0]        px_s1, py_s1, pz_s1;
	logic [RAD_W-1:0]           s_sum;
	csa_item_t                  item_s2;

	assign en       = !v_s2 || !q_full;
	assign in_ready = en;

	assign x_in = in_data[COMP_W-1:0];
	assign y_in = in_data[2*COMP_W-1:COMP_W];
	assign z_in = in_data[3*COMP_W-1:2*COMP_W];
	assign ax   = x_in[COMP_W-1] ? COMP_W'(-x_in) : COMP_W'(x_in);
	assign ay   = y_in[COMP_W-1] ? COMP_W'(-y_in) : COMP_W'(y_in);
	assign az   = z_in[COMP_W-1] ? COMP_W'(-z_in) : COMP_W'(z_in);

	assign s_sum = px_s1 + py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x_in;
			y_s1  <= y_in;
			z_s1  <= z_in;
			px_s1 <= ax * ax;
			py_s1 <= ay * ay;
			pz_s1 <= az * az;
			item_s2.s              <= s_sum;
			item_s2.side.x         <= x_s1;
			item_s2.side.y         <= y_s1;
			item_s2.side.z         <= z_s1;
			item_s2.side.tag.cap   <= z_s1[COMP_W-1] && (s_sum != '0) && (s_sum < pz_s1);
			item_s2.side.tag.degen <= (s_sum == '0) && (z_s1 == '0);
		end
	end

	assign q_push = v_s2 && !q_full;
	assign q_item = item_s2;

endmodule

>>> rtl/csa_queue.sv
// short first-word-fall-through queue between front and back
module csa_queue import csa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  csa_item_t  push_item,
	output logic       full,
	input  logic       pop,
	output csa_item_t  pop_item,
	output logic       empty
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);

	csa_item_t        mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [PtrW:0]    cnt_q;

	assign full     = cnt_q == (PtrW+1)'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

>>> rtl/csa_sqrt.sv
// pipelined restoring square root, one result bit per stage
module csa_sqrt import csa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [RAD_W-1:0]   in_rad,
	input  csa_side_t          in_side,
	output logic               out_valid,
	output logic [ROOT_W-1:0]  out_root,
	output logic [REM_W-1:0]   out_rem,
	output csa_side_t          out_side
);

	logic [SQRT_STEPS-1:0]  v_q;
	logic [REM_W-1:0]       rem_q  [SQRT_STEPS];
	logic [ROOT_W-1:0]      root_q [SQRT_STEPS];
	logic [RAD_W-1:0]       rad_q  [SQRT_STEPS];
	csa_side_t              side_q [SQRT_STEPS];

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		logic              v_p;
		logic [REM_W-1:0]  rem_p, cat, trial;
		logic [ROOT_W-1:0] root_p;
		logic [RAD_W-1:0]  rad_p;
		csa_side_t         side_p;
		logic              ge;

		if (i == 0) begin : g_first
			assign v_p    = in_valid;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = in_rad;
			assign side_p = in_side;
		end else begin : g_next
			assign v_p    = v_q[i-1];
			assign rem_p  = rem_q[i-1];
			assign root_p = root_q[i-1];
			assign rad_p  = rad_q[i-1];
			assign side_p = side_q[i-1];
		end

		// remainder stays below 2^33, so its top two bits are free
		assign cat   = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};
		assign ge    = cat >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= ge ? cat - trial : cat;
				root_q[i] <= {root_p[ROOT_W-2:0], ge};
				rad_q[i]  <= {rad_p[RAD_W-3:0], 2'b00};
				side_q[i] <= side_p;
			end
		end
	end

	assign out_valid = v_q[SQRT_STEPS-1];
	assign out_root  = root_q[SQRT_STEPS-1];
	assign out_rem   = rem_q[SQRT_STEPS-1];
	assign out_side  = side_q[SQRT_STEPS-1];

endmodule

>>> rtl/csa_div.sv
// pipelined rounding divider with 32-bit saturation, one quotient bit per stage
module csa_div import csa_pkg::*; #(
	parameter int NUM_W = COMP_W + FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [NUM_W-1:0]   in_num,
	input  logic [DEN_W-1:0]   in_den,
	input  logic               in_neg,
	input  csa_tag_t           in_tag,
	output logic               out_valid,
	output logic [COMP_W-1:0]  out_quo,
	output csa_tag_t           out_tag
);

	localparam int RW = DEN_W + 1;

	// init stage: overflow check and top of the numerator
	logic               v_s1, ovf_s1, neg_s1;
	logic [RW-1:0]      rem_s1;
	logic [COMP_W-1:0]  w_s1;
	logic [DEN_W-1:0]   den_s1;
	csa_tag_t           tag_s1;
	logic [RW-1:0]      hi;

	assign hi = RW'(in_num[NUM_W-1:COMP_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s1 <= hi >= {1'b0, in_den};
			rem_s1 <= hi;
			w_s1   <= in_num[COMP_W-1:0];
			den_s1 <= in_den;
			neg_s1 <= in_neg;
			tag_s1 <= in_tag;
		end
	end

	logic [DIV_STEPS-1:0] v_q;
	logic [DIV_STEPS-1:0] ovf_q, neg_q;
	logic [RW-1:0]        rem_q [DIV_STEPS];
	logic [COMP_W-1:0]    w_q   [DIV_STEPS];
	logic [DEN_W-1:0]     den_q [DIV_STEPS];
	csa_tag_t             tag_q [DIV_STEPS];

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic              v_p, ovf_p, neg_p, ge;
		logic [RW-1:0]     rem_p, cat;
		logic [COMP_W-1:0] w_p;
		logic [DEN_W-1:0]  den_p;
		csa_tag_t          tag_p;

		if (i == 0) begin : g_first
			assign v_p   = v_s1;
			assign ovf_p = ovf_s1;
			assign neg_p = neg_s1;
			assign rem_p = rem_s1;
			assign w_p   = w_s1;
			assign den_p = den_s1;
			assign tag_p = tag_s1;
		end else begin : g_next
			assign v_p   = v_q[i-1];
			assign ovf_p = ovf_q[i-1];
			assign neg_p = neg_q[i-1];
			assign rem_p = rem_q[i-1];
			assign w_p   = w_q[i-1];
			assign den_p = den_q[i-1];
			assign tag_p = tag_q[i-1];
		end

		// numerator bits shift out of w at the top, quotient bits enter at the bottom
		assign cat = {rem_p[RW-2:0], w_p[COMP_W-1]};
		assign ge  = cat >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? cat - {1'b0, den_p} : cat;
				w_q[i]   <= {w_p[COMP_W-2:0], ge};
				ovf_q[i] <= ovf_p;
				neg_q[i] <= neg_p;
				den_q[i] <= den_p;
				tag_q[i] <= tag_p;
			end
		end
	end

	// final stage: round half away, saturate, sign; degenerate items give zero
	localparam int L = DIV_STEPS - 1;

	logic              rnd;
	logic [COMP_W:0]   qf, mag;
	logic [COMP_W-1:0] res;
	logic              v_q_out;
	logic [COMP_W-1:0] quo_q;
	csa_tag_t          tag_out_q;

	assign rnd = {rem_q[L], 1'b0} >= {2'b00, den_q[L]};
	assign qf  = {1'b0, w_q[L]} + (COMP_W+1)'(rnd);
	assign mag = ovf_q[L] ? {1'b1, {COMP_W{1'b0}}} : qf;

	always_comb begin
		if (tag_q[L].degen) begin
			res = '0;
		end else if (neg_q[L]) begin
			res = (mag >= {2'b01, {(COMP_W-1){1'b0}}}) ? {1'b1, {(COMP_W-1){1'b0}}}
				: COMP_W'(-mag[COMP_W-1:0]);
		end else begin
			res = (mag >= {2'b01, {(COMP_W-1){1'b0}}}) ? {1'b0, {(COMP_W-1){1'b1}}}
				: mag[COMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q_out <= 1'b0;
		end else if (en) begin
			v_q_out <= v_q[L];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q     <= res;
			tag_out_q <= tag_q[L];
		end
	end

	assign out_valid = v_q_out;
	assign out_quo   = quo_q;
	assign out_tag   = tag_out_q;

endmodule

>>> rtl/cone_surface_anchor_unit.sv
// top level of the cone surface anchor unit: front, queue and back pipeline
// throughput: one vector per cycle while the output is not stalled,
// set by the fully pipelined root and dividers
// root: 32 stages, one bit each; dividers: 34 stages (check, 32 bits, round)
// reset: arst_n clears all valid bits and queue pointers; no data is cleared
// a stalled output holds the back pipeline; the queue lets the front keep taking items
module cone_surface_anchor_unit import csa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [DATA_W-1:0]  s_tdata,  // dir_x, dir_y, dir_z
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [DATA_W-1:0]  m_tdata,  // anchor_x, anchor_y, anchor_z
	output logic [USER_W-1:0]  m_tuser   // cap_hit, degenerate, zero fill
);

	localparam int NUM_W = COMP_W + FRAC_BITS;

	// front and queue
	logic       q_push, q_full;
	csa_item_t  push_item, head;
	logic       q_empty, pop, en_back;

	csa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	csa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (head),
		.empty     (q_empty)
	);

	// whole back pipeline moves together, held only by the output register
	assign en_back = !m_tvalid || m_tready;
	assign pop     = en_back && !q_empty;

	// root and remainder of x^2 + y^2; stage 1 rounds the root
	logic               sq_valid;
	logic [ROOT_W-1:0]  sq_root;
	logic [REM_W-1:0]   sq_rem;
	csa_side_t          sq_side;

	csa_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_back),
		.in_valid  (pop),
		.in_rad    (head.s),
		.in_side   (head.side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_rem   (sq_rem),
		.out_side  (sq_side)
	);

	// stage 1: denominator 4r + 2z of the slanted side
	logic                    v_s1;
	logic signed [DEN_W-1:0] d_s1;
	csa_side_t               side_s1;
	logic [ROOT_W:0]         r_rnd;

	assign r_rnd = {1'b0, sq_root} + (ROOT_W+1)'(sq_rem > REM_W'(sq_root));

	// stage 2: magnitudes, shifts and signs for the three divisions
	logic                    v_s2;
	logic [NUM_W-1:0]        nx_s2, ny_s2, nz_s2;
	logic [DEN_W-1:0]        den_s2;
	logic                    gx_s2, gy_s2, gz_s2;
	csa_tag_t                tag_s2;
	logic [COMP_W-1:0]       ax1, ay1, az1;
	logic                    d_neg;
	logic [DEN_W-1:0]        d_mag;

	assign ax1   = side_s1.x[COMP_W-1] ? COMP_W'(-side_s1.x) : COMP_W'(side_s1.x);
	assign ay1   = side_s1.y[COMP_W-1] ? COMP_W'(-side_s1.y) : COMP_W'(side_s1.y);
	assign az1   = side_s1.z[COMP_W-1] ? COMP_W'(-side_s1.z) : COMP_W'(side_s1.z);
	assign d_neg = !side_s1.tag.cap && d_s1[DEN_W-1];
	// the cap divides by |z| with half scale, the side by 4r + 2z with full scale
	assign d_mag = side_s1.tag.cap ? DEN_W'(az1)
		: (d_s1[DEN_W-1] ? DEN_W'(-d_s1) : DEN_W'(d_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en_back) begin
			v_s1 <= sq_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_back) begin
			d_s1    <= $signed({1'b0, r_rnd, 2'b00})
				+ $signed({{(DEN_W-COMP_W-1){sq_side.z[COMP_W-1]}}, sq_side.z, 1'b0});
			side_s1 <= sq_side;
			nx_s2   <= side_s1.tag.cap ? NUM_W'(ax1) << (FRAC_BITS - 1) : NUM_W'(ax1) << FRAC_BITS;
			ny_s2   <= side_s1.tag.cap ? NUM_W'(ay1) << (FRAC_BITS - 1) : NUM_W'(ay1) << FRAC_BITS;
			nz_s2   <= side_s1.tag.cap ? NUM_W'(az1) << (FRAC_BITS - 1) : NUM_W'(az1) << FRAC_BITS;
			den_s2  <= d_mag;
			gx_s2   <= side_s1.x[COMP_W-1] ^ d_neg;
			gy_s2   <= side_s1.y[COMP_W-1] ^ d_neg;
			gz_s2   <= side_s1.z[COMP_W-1] ^ d_neg;
			tag_s2  <= side_s1.tag;
		end
	end

	// three dividers in lockstep; the x divider's valid and flags drive the output
	logic               vx, vy, vz;
	logic [COMP_W-1:0]  qx, qy, qz;
	csa_tag_t           tx, ty, tz;

	csa_div #(.NUM_W(NUM_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en_back), .in_valid(v_s2),
		.in_num(nx_s2), .in_den(den_s2), .in_neg(gx_s2), .in_tag(tag_s2),
		.out_valid(vx), .out_quo(qx), .out_tag(tx)
	);

	csa_div #(.NUM_W(NUM_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en_back), .in_valid(v_s2),
		.in_num(ny_s2), .in_den(den_s2), .in_neg(gy_s2), .in_tag(tag_s2),
		.out_valid(vy), .out_quo(qy), .out_tag(ty)
	);

	csa_div #(.NUM_W(NUM_W)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en_back), .in_valid(v_s2),
		.in_num(nz_s2), .in_den(den_s2), .in_neg(gz_s2), .in_tag(tag_s2),
		.out_valid(vz), .out_quo(qz), .out_tag(tz)
	);

	assign m_tvalid = vx;
	assign m_tdata  = {qz, qy, qx};
	assign m_tuser  = {{(USER_W-2){1'b0}}, tx.degen, tx.cap};

`ifndef SYNTHESIS
	localparam logic [COMP_W-1:0] CapZ = COMP_W'(0) - (COMP_W'(1) << (FRAC_BITS - 1));

	// zero vector gives a zero anchor and never a cap hit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
		else $error("degenerate result not zero");

	// the three dividers must move and carry flags together
	assert property (@(posedge clk) disable iff (!arst_n)
		(vy == vx) && (vz == vx) && (!vx || (ty == tx && tz == tx)))
		else $error("dividers out of step");

	// on the cap plane z is always exactly minus one half
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[3*COMP_W-1:2*COMP_W] == CapZ)
		else $error("cap anchor z not at the cap plane");
`endif

endmodule

>>> dv/cone_surface_anchor_unit_checker.sv
// checker for the cone surface anchor unit: predicts each anchor and compares outputs
`timescale 1ns / 100ps
module cone_surface_anchor_unit_checker import csa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,
	input  logic [USER_W-1:0] m_tuser,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic        cap;
		logic        degen;
	} anchor_t;

	anchor_t anchor_q[$];

	assign pending = anchor_q.size();

	// rounded square root of a 64-bit magnitude
	function automatic longint unsigned root_round(input longint unsigned s);
		longint unsigned op, res, one;
		op = s;
		res = 0;
		one = 64'd1 << 62;
		while (one > op)
			one >>= 2;
		while (one != 0) begin
			if (op >= res + one) begin
				op -= res + one;
				res = (res >> 1) + one;
			end else begin
				res >>= 1;
			end
			one >>= 2;
		end
		if (op > res)
			res++;
		return res;
	endfunction

	// quotient rounded half away from zero, saturated to 32 bits
	function automatic logic [31:0] quot_sat(input logic signed [95:0] num,
			input logic signed [95:0] den);
		logic [95:0] n, d, q, rem;
		logic neg;
		logic signed [95:0] v;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		neg = (num < 0) != (den < 0);
		if (d == 0)
			return 32'd0;
		q = n / d;
		rem = n % d;
		if (rem >= d - rem)
			q++;
		v = neg ? -$signed(q) : $signed(q);
		if (v > 96'sd2147483647)
			return 32'h7fffffff;
		if (v < -96'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic anchor_t predict_anchor(input logic [DATA_W-1:0] d);
		logic signed [95:0] x, y, z, den, scale;
		logic [95:0] s, z2;
		anchor_t a;
		x = $signed(d[31:0]);
		y = $signed(d[63:32]);
		z = $signed(d[95:64]);
		s = x * x + y * y;
		z2 = z * z;
		a = '0;
		if (s == 0 && z == 0) begin
			a.degen = 1'b1;
		end else begin
			if (z < 0 && s != 0 && s < z2) begin
				// cap plane: scale by half over |z|
				a.cap = 1'b1;
				den = -z;
				scale = 96'sd1 << (FRAC_BITS - 1);
			end else begin
				den = 4 * $signed({32'd0, root_round(s[63:0])}) + 2 * z;
				scale = 96'sd1 << FRAC_BITS;
			end
			a.ax = quot_sat(x * scale, den);
			a.ay = quot_sat(y * scale, den);
			a.az = quot_sat(z * scale, den);
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		anchor_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				anchor_q = {anchor_q, predict_anchor(s_tdata)};
			if (m_tvalid && m_tready) begin
				if (anchor_q.size() == 0) begin
					$error("unexpected result transfer %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					e = anchor_q.pop_front();
					if (e.ax !== m_tdata[31:0] || e.ay !== m_tdata[63:32] ||
							e.az !== m_tdata[95:64] || e.cap !== m_tuser[0] ||
							e.degen !== m_tuser[1])
						fail_count <= fail_count + 1;
					if (e.ax !== m_tdata[31:0])
						$error("anchor_x exp %h got %h", e.ax, m_tdata[31:0]);
					if (e.ay !== m_tdata[63:32])
						$error("anchor_y exp %h got %h", e.ay, m_tdata[63:32]);
					if (e.az !== m_tdata[95:64])
						$error("anchor_z exp %h got %h", e.az, m_tdata[95:64]);
					if (e.cap !== m_tuser[0])
						$error("cap_hit exp %b got %b", e.cap, m_tuser[0]);
					if (e.degen !== m_tuser[1])
						$error("degenerate exp %b got %b", e.degen, m_tuser[1]);
				end
			end
		end
	end

endmodule

>>> dv/cone_surface_anchor_unit_tb.sv
// testbench top for the cone surface anchor unit: stimulus, stalls and verdict
`timescale 1ns / 100ps
module cone_surface_anchor_unit_tb import csa_pkg::*; ;

	localparam int RANDOM_VECTORS = 1200;
	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD = 300;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;
	int                fail_count;
	int                pending;
	logic              stim_done;
	logic              hold_done;
	int                idle_cycles;

	cone_surface_anchor_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	cone_surface_anchor_unit_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(9) < 6 ? 0 : $urandom_range(3, 1);
	endfunction

	// pick a component: extremes, small values near the cone's scale, or anything
	function automatic logic [31:0] pick_comp();
		case ($urandom_range(7))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'd0;
			3, 4: return $urandom_range(32'h40000) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	// hand one vector over, waiting for the transfer
	task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		int g;
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// receiver: a long hold early on, then random stalls
	initial begin
		int g;
		m_tready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		repeat (LONG_HOLD) @(posedge clk);
		hold_done <= 1'b1;
		forever begin
			m_tready <= 1'b1;
			@(posedge clk);
			g = $urandom_range(2) == 0 ? gap_len() : 0;
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (!stim_done || pending != 0) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int w;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		stim_done = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero vector, axis both ways, cap and side, zero denominator, extremes
		send_vector(32'd0, 32'd0, 32'd0);
		send_vector(32'd0, 32'd0, 32'h00010000);
		send_vector(32'd0, 32'd0, 32'hffff0000);
		send_vector(32'h00010000, 32'd0, 32'hfffe0000);
		send_vector(32'h00010000, 32'd0, 32'hffff0000);
		send_vector(32'd0, 32'h00010000, 32'h00010000);
		send_vector(32'h00008000, 32'd0, 32'hffff0000);
		send_vector(32'd3, 32'd4, 32'hfffffff6);
		send_vector(32'h80000000, 32'h80000000, 32'h80000000);
		send_vector(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_vector(32'h80000000, 32'h7fffffff, 32'h80000000);
		send_vector(32'd1, 32'd0, 32'h80000000);
		send_vector(32'd0, 32'hffffffff, 32'h7fffffff);
		send_vector(32'd1, 32'd1, 32'd0);
		send_vector(32'h7fffffff, 32'd0, 32'd0);
		send_vector(32'hffffffff, 32'hffffffff, 32'hfffffffe);
		send_vector(32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_vector(32'h5555aaaa, 32'haaaa5555, 32'hc0000000);
		// random part: sender keeps offering during the long receiver hold
		for (int i = 0; i < RANDOM_VECTORS; i++)
			send_vector(pick_comp(), pick_comp(), pick_comp());
		s_tvalid <= 1'b0;
		stim_done <= 1'b1;
		w = 0;
		while ((pending != 0 || !hold_done) && w < 100000) begin
			@(posedge clk);
			w++;
		end
		repeat (200) @(posedge clk);
		if (pending == 0 && fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/csa_pkg.sv
rtl/csa_front.sv
rtl/csa_queue.sv
rtl/csa_sqrt.sv
rtl/csa_div.sv
rtl/cone_surface_anchor_unit.sv
dv/cone_surface_anchor_unit_checker.sv
dv/cone_surface_anchor_unit_tb.sv
